FILE: sv/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared types and constants for the transfinite grid interpolator.
// ----------------------------------------------------------------------------
package tgi_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_W          = 7;
  localparam int IDX_W          = 6;
  localparam int COORD_W        = 32;
  localparam int PTS_MIN        = 2;
  localparam logic [CFG_W-1:0] PTS_RESET = 7'd64;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } tgi_act_t;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_TOP    = 2'd3
  } tgi_side_t;

  typedef enum logic {
    CFG_POINTS_X = 1'b0,
    CFG_POINTS_Y = 1'b1
  } tgi_cfg_t;

  typedef struct packed {
    tgi_act_t                   action;
    tgi_side_t                  side;
    logic [IDX_W-1:0]           load_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic [IDX_W-1:0]           grid_i;
    logic [IDX_W-1:0]           grid_j;
  } tgi_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  grid_x;
    logic signed [COORD_W-1:0]  grid_y;
    logic                       status;
  } tgi_out_t;

  // input word plus the out-of-grid flag worked out at entry
  typedef struct packed {
    tgi_in_t word;
    logic    oob;
  } tgi_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } tgi_pt_t;

  // boundary store write request
  typedef struct packed {
    logic             en;
    tgi_side_t        side;
    logic [IDX_W-1:0] index;
    tgi_pt_t          pt;
  } tgi_wr_t;

  // boundary points read for one query
  typedef struct packed {
    tgi_pt_t l_j;
    tgi_pt_t r_j;
    tgi_pt_t b_i;
    tgi_pt_t t_i;
    tgi_pt_t t_n;
    tgi_pt_t l_0;
    tgi_pt_t r_0;
    tgi_pt_t t_0;
  } tgi_rd_t;

endpackage

FILE: sv/transfinite_grid_interpolation.sv
// a word passes the divider stages, weight products, rounded weights, blend stages
//   and the output register
// throughput: one word per cycle, loads and queries alike; a stalled output
//   freezes every stage
// reset: synchronous active low; clears valid bits and sets both grid sizes to 64,
//   boundary memories keep their contents
// ----------------------------------------------------------------------------
// transfinite_grid_interpolation
// Coons patch grid interpolator: loads boundary points into side memories
// and returns the blended x and y for each queried grid point.
// ----------------------------------------------------------------------------
module transfinite_grid_interpolation #(
  parameter int FRAC_BITS  = tgi_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tgi_pkg::tgi_in_t            in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tgi_pkg::tgi_out_t           out_word,
  input  logic                        cfg_we,
  input  tgi_pkg::tgi_cfg_t           cfg_index,
  input  logic [tgi_pkg::CFG_W-1:0]   cfg_data
);

  localparam int MAX_POINTS = tgi_pkg::MAX_POINTS_DEF;
  localparam int AW = tgi_pkg::IDX_W;
  localparam int NB = tgi_pkg::CFG_W;
  localparam int WW = FRAC_BITS + 1;
  localparam logic [WW-1:0]   ONE  = WW'(1) << FRAC_BITS;
  localparam logic [2*WW-1:0] HALF = (2*WW)'(1) << (FRAC_BITS - 1);

  logic [NB-1:0] points_x_r, points_y_r;
  logic [NB-1:0] nx, ny, dx, dy;
  logic          adv;

  tgi_pkg::tgi_item_t in_item;
  logic               d_vld;
  tgi_pkg::tgi_item_t d_item;
  logic [WW-1:0]      d_q, d_r;

  logic               vw_r;
  tgi_pkg::tgi_item_t itw_r;
  logic [WW-1:0]      qw_r, rw_r;
  logic [2*WW-1:0]    p00w_r, p10w_r, p01w_r, p11w_r;

  logic               va_r, qrya_r, ooba_r;
  logic [WW-1:0]      qa_r, ra_r, cw00a_r, cw10a_r, cw01a_r, cw11a_r;

  logic [2:0]         v_tail_r, qry_tail_r, oob_tail_r;

  tgi_pkg::tgi_wr_t   wr;
  tgi_pkg::tgi_rd_t   rd;
  logic               ld_ok;
  logic signed [tgi_pkg::COORD_W-1:0] res_x, res_y;

  logic               out_valid_r;
  tgi_pkg::tgi_out_t  out_word_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_x_r <= tgi_pkg::PTS_RESET;
      points_y_r <= tgi_pkg::PTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tgi_pkg::CFG_POINTS_X: points_x_r <= cfg_data;
        tgi_pkg::CFG_POINTS_Y: points_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective grid size, clamped between PTS_MIN and the store depth
  always_comb begin
    if (points_x_r < NB'(tgi_pkg::PTS_MIN)) begin
      nx = NB'(tgi_pkg::PTS_MIN);
    end else if (32'(points_x_r) > MAX_POINTS) begin
      nx = NB'(MAX_POINTS);
    end else begin
      nx = points_x_r;
    end
    if (points_y_r < NB'(tgi_pkg::PTS_MIN)) begin
      ny = NB'(tgi_pkg::PTS_MIN);
    end else if (32'(points_y_r) > MAX_POINTS) begin
      ny = NB'(MAX_POINTS);
    end else begin
      ny = points_y_r;
    end
    dx = nx - NB'(1);
    dy = ny - NB'(1);
  end

  // whole pipeline moves unless the output word is held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    in_item.word = in_word;
    in_item.oob  = (NB'(in_word.grid_i) >= nx) || (NB'(in_word.grid_j) >= ny);
  end

  tgi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_item  (in_item),
    .dx       (dx),
    .dy       (dy),
    .out_vld  (d_vld),
    .out_item (d_item),
    .out_q    (d_q),
    .out_r    (d_r)
  );

  // corner weight products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0;
    end else if (adv) begin
      vw_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itw_r  <= d_item;
      qw_r   <= d_q;
      rw_r   <= d_r;
      p00w_r <= (ONE - d_q) * (ONE - d_r);
      p10w_r <= d_q * (ONE - d_r);
      p01w_r <= (ONE - d_q) * d_r;
      p11w_r <= d_q * d_r;
    end
  end

  // boundary writes and reads happen in order at this stage
  assign ld_ok = (32'(itw_r.word.load_index) < MAX_POINTS);

  always_comb begin
    wr.en    = adv && vw_r && (itw_r.word.action == tgi_pkg::ACT_LOAD) && ld_ok;
    wr.side  = itw_r.word.side;
    wr.index = itw_r.word.load_index;
    wr.pt.x  = itw_r.word.coord_x;
    wr.pt.y  = itw_r.word.coord_y;
  end

  tgi_store u_store (
    .clk    (clk),
    .rd_en  (adv),
    .wr     (wr),
    .addr_i (AW'(itw_r.word.grid_i)),
    .addr_j (AW'(itw_r.word.grid_j)),
    .addr_n (AW'(dx)),
    .rd     (rd)
  );

  // rounded corner weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= vw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qrya_r  <= (itw_r.word.action == tgi_pkg::ACT_QUERY);
      ooba_r  <= itw_r.oob;
      qa_r    <= qw_r;
      ra_r    <= rw_r;
      cw00a_r <= WW'((p00w_r + HALF) >> FRAC_BITS);
      cw10a_r <= WW'((p10w_r + HALF) >> FRAC_BITS);
      cw01a_r <= WW'((p01w_r + HALF) >> FRAC_BITS);
      cw11a_r <= WW'((p11w_r + HALF) >> FRAC_BITS);
    end
  end

  tgi_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend_x (
    .clk  (clk),
    .adv  (adv),
    .q    (qa_r),
    .r    (ra_r),
    .cw00 (cw00a_r),
    .cw10 (cw10a_r),
    .cw01 (cw01a_r),
    .cw11 (cw11a_r),
    .lj   (rd.l_j.x),
    .rj   (rd.r_j.x),
    .bi   (rd.b_i.x),
    .ti   (rd.t_i.x),
    .l0   (rd.l_0.x),
    .r0   (rd.r_0.x),
    .t0   (rd.t_0.x),
    .tn   (rd.t_n.x),
    .res  (res_x)
  );

  tgi_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend_y (
    .clk  (clk),
    .adv  (adv),
    .q    (qa_r),
    .r    (ra_r),
    .cw00 (cw00a_r),
    .cw10 (cw10a_r),
    .cw01 (cw01a_r),
    .cw11 (cw11a_r),
    .lj   (rd.l_j.y),
    .rj   (rd.r_j.y),
    .bi   (rd.b_i.y),
    .ti   (rd.t_i.y),
    .l0   (rd.l_0.y),
    .r0   (rd.r_0.y),
    .t0   (rd.t_0.y),
    .tn   (rd.t_n.y),
    .res  (res_y)
  );

  // flags ride along the three blend stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_tail_r <= '0;
    end else if (adv) begin
      v_tail_r <= {v_tail_r[1:0], va_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qry_tail_r <= {qry_tail_r[1:0], qrya_r};
      oob_tail_r <= {oob_tail_r[1:0], ooba_r};
    end
  end

  // output register, loads leave no word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_tail_r[2] && qry_tail_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r.grid_x <= oob_tail_r[2] ? '0 : res_x;
      out_word_r.grid_y <= oob_tail_r[2] ? '0 : res_y;
      out_word_r.status <= oob_tail_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: sv/tgi_div.sv
// ----------------------------------------------------------------------------
// tgi_div
// Pipelined restoring divider: forms q = i/(nx-1) and r = j/(ny-1) with
// rounding, one quotient bit per stage, carrying the word alongside.
// ----------------------------------------------------------------------------
module tgi_div #(
  parameter int FRAC_BITS = tgi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  tgi_pkg::tgi_item_t                in_item,
  input  logic [tgi_pkg::CFG_W-1:0]         dx,
  input  logic [tgi_pkg::CFG_W-1:0]         dy,
  output logic                              out_vld,
  output tgi_pkg::tgi_item_t                out_item,
  output logic [FRAC_BITS:0]                out_q,
  output logic [FRAC_BITS:0]                out_r
);

  localparam int NW = tgi_pkg::IDX_W + FRAC_BITS + 1;
  localparam int DW = tgi_pkg::CFG_W;

  logic               vld_r  [NW];
  tgi_pkg::tgi_item_t item_r [NW];
  logic [NW-1:0]      qn_r   [NW];
  logic [NW-1:0]      rn_r   [NW];
  logic [DW-1:0]      qrem_r [NW];
  logic [DW-1:0]      rrem_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic               v_in;
    tgi_pkg::tgi_item_t it_in;
    logic [NW-1:0]      qn_in, rn_in;
    logic [DW-1:0]      qrem_in, rrem_in;
    logic [DW:0]        qrem2, rrem2;
    logic               qge, rge;

    if (k == 0) begin : g_first
      // rounded numerator: (idx << F) + (d >> 1)
      assign v_in    = in_vld;
      assign it_in   = in_item;
      assign qn_in   = (NW'(in_item.word.grid_i) << FRAC_BITS) + NW'(dx >> 1);
      assign rn_in   = (NW'(in_item.word.grid_j) << FRAC_BITS) + NW'(dy >> 1);
      assign qrem_in = '0;
      assign rrem_in = '0;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign it_in   = item_r[k-1];
      assign qn_in   = qn_r[k-1];
      assign rn_in   = rn_r[k-1];
      assign qrem_in = qrem_r[k-1];
      assign rrem_in = rrem_r[k-1];
    end

    // one compare-subtract step per lane
    assign qrem2 = {qrem_in, qn_in[NW-1]};
    assign rrem2 = {rrem_in, rn_in[NW-1]};
    assign qge   = (qrem2 >= {1'b0, dx});
    assign rge   = (rrem2 >= {1'b0, dy});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        item_r[k] <= it_in;
        qn_r[k]   <= {qn_in[NW-2:0], qge};
        rn_r[k]   <= {rn_in[NW-2:0], rge};
        qrem_r[k] <= qge ? DW'(qrem2 - {1'b0, dx}) : qrem2[DW-1:0];
        rrem_r[k] <= rge ? DW'(rrem2 - {1'b0, dy}) : rrem2[DW-1:0];
      end
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_item = item_r[NW-1];
  assign out_q    = qn_r[NW-1][FRAC_BITS:0];
  assign out_r    = rn_r[NW-1][FRAC_BITS:0];

endmodule

FILE: sv/tgi_store.sv
// ----------------------------------------------------------------------------
// tgi_store
// Boundary point memories for the four sides, with registered reads and
// corner copies of the first left, right and top entries.
// ----------------------------------------------------------------------------
module tgi_store (
  input  logic                             clk,
  input  logic                             rd_en,
  input  tgi_pkg::tgi_wr_t                 wr,
  input  logic [tgi_pkg::IDX_W-1:0]        addr_i,
  input  logic [tgi_pkg::IDX_W-1:0]        addr_j,
  input  logic [tgi_pkg::IDX_W-1:0]        addr_n,
  output tgi_pkg::tgi_rd_t                 rd
);

  localparam int MAX_POINTS = tgi_pkg::MAX_POINTS_DEF;
  localparam int AW = $clog2(MAX_POINTS);

  tgi_pkg::tgi_pt_t mem_left   [MAX_POINTS];
  tgi_pkg::tgi_pt_t mem_right  [MAX_POINTS];
  tgi_pkg::tgi_pt_t mem_bottom [MAX_POINTS];
  tgi_pkg::tgi_pt_t mem_top    [MAX_POINTS];
  tgi_pkg::tgi_pt_t left0_r, right0_r, top0_r;
  tgi_pkg::tgi_rd_t rd_r;
  logic [AW-1:0]    wr_addr;

  assign wr_addr = AW'(wr.index);

  // write port, one side per word
  always_ff @(posedge clk) begin
    if (wr.en) begin
      case (wr.side)
        tgi_pkg::SIDE_LEFT: begin
          mem_left[wr_addr] <= wr.pt;
          if (wr_addr == '0) left0_r <= wr.pt;
        end
        tgi_pkg::SIDE_RIGHT: begin
          mem_right[wr_addr] <= wr.pt;
          if (wr_addr == '0) right0_r <= wr.pt;
        end
        tgi_pkg::SIDE_BOTTOM: begin
          mem_bottom[wr_addr] <= wr.pt;
        end
        default: begin
          mem_top[wr_addr] <= wr.pt;
          if (wr_addr == '0) top0_r <= wr.pt;
        end
      endcase
    end
  end

  // registered reads, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.l_j <= mem_left[AW'(addr_j)];
      rd_r.r_j <= mem_right[AW'(addr_j)];
      rd_r.b_i <= mem_bottom[AW'(addr_i)];
      rd_r.t_i <= mem_top[AW'(addr_i)];
      rd_r.t_n <= mem_top[AW'(addr_n)];
      rd_r.l_0 <= left0_r;
      rd_r.r_0 <= right0_r;
      rd_r.t_0 <= top0_r;
    end
  end

  assign rd = rd_r;

endmodule

FILE: sv/tgi_blend.sv
// ----------------------------------------------------------------------------
// tgi_blend
// Blends one coordinate: eight weighted terms, two adder stages, then
// rounding to Q16.16 and saturation.
// ----------------------------------------------------------------------------
module tgi_blend #(
  parameter int FRAC_BITS = tgi_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   adv,
  input  logic [FRAC_BITS:0]                     q,
  input  logic [FRAC_BITS:0]                     r,
  input  logic [FRAC_BITS:0]                     cw00,
  input  logic [FRAC_BITS:0]                     cw10,
  input  logic [FRAC_BITS:0]                     cw01,
  input  logic [FRAC_BITS:0]                     cw11,
  input  logic signed [tgi_pkg::COORD_W-1:0]     lj,
  input  logic signed [tgi_pkg::COORD_W-1:0]     rj,
  input  logic signed [tgi_pkg::COORD_W-1:0]     bi,
  input  logic signed [tgi_pkg::COORD_W-1:0]     ti,
  input  logic signed [tgi_pkg::COORD_W-1:0]     l0,
  input  logic signed [tgi_pkg::COORD_W-1:0]     r0,
  input  logic signed [tgi_pkg::COORD_W-1:0]     t0,
  input  logic signed [tgi_pkg::COORD_W-1:0]     tn,
  output logic signed [tgi_pkg::COORD_W-1:0]    res
);

  localparam int CW = tgi_pkg::COORD_W;
  localparam int WW = FRAC_BITS + 1;
  localparam int PW = WW + 1 + CW;
  localparam int SW = PW + 3;
  localparam int RW = SW - FRAC_BITS;
  localparam logic [WW-1:0]        ONE    = WW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] HALF   = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(64'sh7FFF_FFFF);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-64'sh8000_0000);

  logic signed [PW-1:0] mul_r [8];
  logic signed [SW-1:0] pair_r [4];
  logic signed [SW-1:0] tot_r;
  logic signed [SW-1:0] rnd;
  logic signed [RW-1:0] shv;

  function automatic logic signed [PW-1:0] wmul(input logic [WW-1:0] w,
                                                input logic signed [CW-1:0] c);
    logic signed [WW:0] ws;
    begin
      ws   = $signed({1'b0, w});
      wmul = ws * c;
    end
  endfunction

  // side terms and corner terms
  always_ff @(posedge clk) begin
    if (adv) begin
      mul_r[0] <= wmul(ONE - q, lj);
      mul_r[1] <= wmul(q, rj);
      mul_r[2] <= wmul(ONE - r, bi);
      mul_r[3] <= wmul(r, ti);
      mul_r[4] <= wmul(cw00, l0);
      mul_r[5] <= wmul(cw10, r0);
      mul_r[6] <= wmul(cw01, t0);
      mul_r[7] <= wmul(cw11, tn);
    end
  end

  // pairwise sums
  always_ff @(posedge clk) begin
    if (adv) begin
      pair_r[0] <= SW'(mul_r[0]) + SW'(mul_r[1]);
      pair_r[1] <= SW'(mul_r[2]) + SW'(mul_r[3]);
      pair_r[2] <= SW'(mul_r[4]) + SW'(mul_r[5]);
      pair_r[3] <= SW'(mul_r[6]) + SW'(mul_r[7]);
    end
  end

  // sides minus corners
  always_ff @(posedge clk) begin
    if (adv) begin
      tot_r <= pair_r[0] + pair_r[1] - pair_r[2] - pair_r[3];
    end
  end

  // round half up to the output grid, then clamp
  always_comb begin
    rnd = tot_r + HALF;
    shv = rnd[SW-1:FRAC_BITS];
    if (shv > SAT_HI) begin
      res = SAT_HI[CW-1:0];
    end else if (shv < SAT_LO) begin
      res = SAT_LO[CW-1:0];
    end else begin
      res = shv[CW-1:0];
    end
  end

endmodule

FILE: sv/tgi_checker.sv
// ----------------------------------------------------------------------------
// tgi_checker
// Port-level checks on the interpolator's result channel and flow control.
// ----------------------------------------------------------------------------
module tgi_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input tgi_pkg::tgi_out_t          out_word
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // out-of-grid queries return zero coordinates
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status |-> out_word.grid_x == 0 && out_word.grid_y == 0)
    else $error("out-of-grid result with nonzero coordinates");

  // input only backs up behind a held output word
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind transfinite_grid_interpolation tgi_checker u_tgi_checker (.*);
